// ===== hw/rtl/tbc_pkg.sv =====
package tbc_pkg;

  // stages ahead of the divider: diff, mul, dot, partial, product, d/n, d-n, num, abs, ovf
  localparam int unsigned PreDivStages = 10;

  function automatic int unsigned lane_stages(input int unsigned coord_width);
    return PreDivStages + coord_width + 1;
  endfunction

endpackage

// ===== hw/rtl/tbc_in_if.sv =====
interface tbc_in_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic signed [COORD_WIDTH-1:0] vert_a_x;
  logic signed [COORD_WIDTH-1:0] vert_a_y;
  logic signed [COORD_WIDTH-1:0] vert_a_z;
  logic signed [COORD_WIDTH-1:0] vert_b_x;
  logic signed [COORD_WIDTH-1:0] vert_b_y;
  logic signed [COORD_WIDTH-1:0] vert_b_z;
  logic signed [COORD_WIDTH-1:0] vert_c_x;
  logic signed [COORD_WIDTH-1:0] vert_c_y;
  logic signed [COORD_WIDTH-1:0] vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

// ===== hw/rtl/tbc_out_if.sv =====
interface tbc_out_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] weight_a;
  logic signed [COORD_WIDTH-1:0] weight_b;
  logic signed [COORD_WIDTH-1:0] weight_c;
  logic degenerate;

  modport source (
    output valid, weight_a, weight_b, weight_c, degenerate,
    input  ready
  );
  modport sink (
    input  valid, weight_a, weight_b, weight_c, degenerate,
    output ready
  );
endinterface

// ===== hw/rtl/triangle_barycentric_coords.sv =====
// Barycentric weights of a 3D point against triangle ABC, all signed fixed point
// with FRAC_BITS fraction bits.
// Input channel in_i: point and three vertices; one query is taken per transfer.
// Output channel out_o: weight_a/b/c, rounded to nearest and saturated, plus
// degenerate, which is set (and all weights zero) for a zero-area triangle.
// Every stage of the datapath is a register; valid bits run alongside the data.
// The restoring divider, one quotient bit per stage, sets most of the pipeline depth.
// Throughput: one query per cycle, sustained while out_o.ready stays high.
// Stall: when out_o.ready is low, the output holds and stages behind it close
// up any empty slots; in_i.ready drops only when every stage holds an item.
// Reset clears all valid bits; the pipeline is empty and ready right after.
module triangle_barycentric_coords #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tbc_in_if.sink    in_i,
  tbc_out_if.source out_o
);
  import tbc_pkg::*;

  localparam int NSt = lane_stages(COORD_WIDTH);

  logic [NSt-1:0]                stage_en;
  logic [NSt-1:0]                valid_q;
  logic [2:0][COORD_WIDTH-1:0]   pnt;
  logic [2:0][COORD_WIDTH-1:0]   va;
  logic [2:0][COORD_WIDTH-1:0]   vb;
  logic [2:0][COORD_WIDTH-1:0]   vc;
  logic signed [COORD_WIDTH-1:0] wa;
  logic signed [COORD_WIDTH-1:0] wb;
  logic signed [COORD_WIDTH-1:0] wc;
  logic                          deg_a;
  logic                          deg_b;
  logic                          deg_c;
  logic                          deg_any;

  // a stage loads when it is empty or its successor moves
  always_comb begin
    stage_en[NSt-1] = !valid_q[NSt-1] || out_o.ready;
    for (int i = NSt - 2; i >= 0; i--) begin
      stage_en[i] = !valid_q[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_i.valid;
      end
      for (int i = 1; i < NSt; i++) begin
        if (stage_en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  assign in_i.ready = stage_en[0];

  assign pnt = {in_i.point_z, in_i.point_y, in_i.point_x};
  assign va  = {in_i.vert_a_z, in_i.vert_a_y, in_i.vert_a_x};
  assign vb  = {in_i.vert_b_z, in_i.vert_b_y, in_i.vert_b_x};
  assign vc  = {in_i.vert_c_z, in_i.vert_c_y, in_i.vert_c_x};

  tbc_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_a (
    .clk_i    (clk_i),
    .en_i     (stage_en),
    .pnt_i    (pnt),
    .org_i    (va),
    .tip_i    (vb),
    .far_i    (vc),
    .weight_o (wa),
    .degen_o  (deg_a)
  );

  tbc_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_b (
    .clk_i    (clk_i),
    .en_i     (stage_en),
    .pnt_i    (pnt),
    .org_i    (vb),
    .tip_i    (vc),
    .far_i    (va),
    .weight_o (wb),
    .degen_o  (deg_b)
  );

  tbc_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_c (
    .clk_i    (clk_i),
    .en_i     (stage_en),
    .pnt_i    (pnt),
    .org_i    (vc),
    .tip_i    (va),
    .far_i    (vb),
    .weight_o (wc),
    .degen_o  (deg_c)
  );

  assign deg_any          = deg_a || deg_b || deg_c;
  assign out_o.valid      = valid_q[NSt-1];
  assign out_o.weight_a   = deg_any ? '0 : wa;
  assign out_o.weight_b   = deg_any ? '0 : wb;
  assign out_o.weight_c   = deg_any ? '0 : wc;
  assign out_o.degenerate = deg_any;

endmodule

// ===== hw/rtl/tbc_lane.sv =====
module tbc_lane #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                           clk_i,
  input  logic [tbc_pkg::lane_stages(COORD_WIDTH)-1:0]   en_i,
  input  logic [2:0][COORD_WIDTH-1:0]                    pnt_i,
  input  logic [2:0][COORD_WIDTH-1:0]                    org_i,
  input  logic [2:0][COORD_WIDTH-1:0]                    tip_i,
  input  logic [2:0][COORD_WIDTH-1:0]                    far_i,
  output logic signed [COORD_WIDTH-1:0]                  weight_o,
  output logic                                           degen_o
);
  import tbc_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = W + 1;
  localparam int PW  = 2 * W + 4;
  localparam int H   = PW / 2;
  localparam int MW  = 2 * PW;
  localparam int DDW = 2 * PW + 1;
  localparam int NW  = DDW + F + 3;
  localparam int CW  = NW + W;
  localparam int NSt = lane_stages(W);
  localparam int StDiv = PreDivStages;

  // dot index: 0 u.w, 1 w.w, 2 u.u, 3 u.x, 4 w.x
  localparam int OpA [4] = '{2, 0, 3, 0};
  localparam int OpB [4] = '{1, 0, 1, 4};

  logic signed [DW-1:0]    u_q [3];
  logic signed [DW-1:0]    w_q [3];
  logic signed [DW-1:0]    x_q [3];
  logic signed [2*DW-1:0]  prod_q [5][3];
  logic signed [PW-1:0]    dot_q [5];
  logic signed [H:0]       a_lo [4];
  logic signed [H:0]       a_hi [4];
  logic signed [H:0]       b_lo [4];
  logic signed [H:0]       b_hi [4];
  logic signed [2*H+1:0]   pp_q [4][4];
  logic signed [MW-1:0]    pw_q [4];
  logic signed [DDW-1:0]   d_q;
  logic signed [DDW-1:0]   n_q;
  logic signed [DDW:0]     dmn_q;
  logic signed [DDW-1:0]   d6_q;
  logic                    deg6_q;
  logic signed [NW-1:0]    num_q;
  logic [DDW:0]            den7_q;
  logic                    deg7_q;
  logic [NW-1:0]           mag8_q;
  logic [DDW:0]            den8_q;
  logic                    neg8_q;
  logic                    deg8_q;
  logic [CW-1:0]           lim;
  logic [CW-1:0]           mag_ext;

  logic [NW-1:0]           rem_q [W+1];
  logic [W-1:0]            quo_q [W+1];
  logic [DDW:0]            den_q [W+1];
  logic                    neg_q [W+1];
  logic                    ovf_q [W+1];
  logic                    deg_q [W+1];

  logic [W-1:0]            rnd;
  logic signed [W-1:0]     res;

  // edge vectors
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= DW'($signed(tip_i[i])) - DW'($signed(org_i[i]));
        w_q[i] <= DW'($signed(tip_i[i])) - DW'($signed(far_i[i]));
        x_q[i] <= DW'($signed(pnt_i[i])) - DW'($signed(org_i[i]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[0][i] <= u_q[i] * w_q[i];
        prod_q[1][i] <= w_q[i] * w_q[i];
        prod_q[2][i] <= u_q[i] * u_q[i];
        prod_q[3][i] <= u_q[i] * x_q[i];
        prod_q[4][i] <= w_q[i] * x_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int k = 0; k < 5; k++) begin
        dot_q[k] <= PW'(prod_q[k][0]) + PW'(prod_q[k][1]) + PW'(prod_q[k][2]);
      end
    end
  end

  // wide products split into signed halves
  always_comb begin
    for (int m = 0; m < 4; m++) begin
      a_lo[m] = $signed({1'b0, dot_q[OpA[m]][H-1:0]});
      a_hi[m] = $signed({dot_q[OpA[m]][PW-1], dot_q[OpA[m]][PW-1:H]});
      b_lo[m] = $signed({1'b0, dot_q[OpB[m]][H-1:0]});
      b_hi[m] = $signed({dot_q[OpB[m]][PW-1], dot_q[OpB[m]][PW-1:H]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int m = 0; m < 4; m++) begin
        pp_q[m][0] <= a_lo[m] * b_lo[m];
        pp_q[m][1] <= a_lo[m] * b_hi[m];
        pp_q[m][2] <= a_hi[m] * b_lo[m];
        pp_q[m][3] <= a_hi[m] * b_hi[m];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      for (int m = 0; m < 4; m++) begin
        pw_q[m] <= MW'(pp_q[m][0])
                 + ((MW'(pp_q[m][1]) + MW'(pp_q[m][2])) <<< H)
                 + (MW'(pp_q[m][3]) <<< (2 * H));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      d_q <= DDW'(pw_q[0]) - DDW'(pw_q[1]);
      n_q <= DDW'(pw_q[2]) - DDW'(pw_q[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      dmn_q  <= (DDW+1)'(d_q) - (DDW+1)'(n_q);
      d6_q   <= d_q;
      deg6_q <= d_q[DDW-1] || (d_q == '0);
    end
  end

  // (D - N) * 2^(F+1) + D over 2D: round half up
  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      num_q  <= (NW'(dmn_q) <<< (F + 1)) + NW'(d6_q);
      den7_q <= {d6_q, 1'b0};
      deg7_q <= deg6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      neg8_q <= num_q[NW-1];
      mag8_q <= num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
      den8_q <= den7_q;
      deg8_q <= deg7_q;
    end
  end

  assign mag_ext = CW'(mag8_q);
  assign lim     = CW'(den8_q) << (W - 1);

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      rem_q[0] <= mag8_q;
      quo_q[0] <= '0;
      den_q[0] <= den8_q;
      neg_q[0] <= neg8_q;
      ovf_q[0] <= neg8_q ? (mag_ext > lim) : (mag_ext >= lim);
      deg_q[0] <= deg8_q;
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int K = W - 1 - j;
    logic [CW-1:0] sub;
    logic          ge;

    assign sub = CW'(den_q[j]) << K;
    assign ge  = CW'(rem_q[j]) >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i[StDiv + j]) begin
        rem_q[j+1] <= ge ? (rem_q[j] - NW'(sub)) : rem_q[j];
        quo_q[j+1] <= quo_q[j] | (W'(ge) << K);
        den_q[j+1] <= den_q[j];
        neg_q[j+1] <= neg_q[j];
        ovf_q[j+1] <= ovf_q[j];
        deg_q[j+1] <= deg_q[j];
      end
    end
  end

  // negative quotient rounds toward minus infinity on the magnitude's ceiling
  assign rnd = quo_q[W] + W'(rem_q[W] != '0);

  always_comb begin
    if (deg_q[W]) begin
      res = '0;
    end else if (ovf_q[W]) begin
      res = neg_q[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else if (neg_q[W]) begin
      res = $signed(-rnd);
    end else begin
      res = $signed(quo_q[W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NSt-1]) begin
      weight_o <= res;
      degen_o  <= deg_q[W];
    end
  end

endmodule

// ===== tb/sv/triangle_barycentric_coords_tb.sv =====
`timescale 1ns / 1ps

module triangle_barycentric_coords_tb;

  localparam int unsigned CW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned N_RANDOM = 1600;

  typedef logic signed [255:0] big_t;

  typedef struct packed {
    logic signed [CW-1:0] px, py, pz;
    logic signed [CW-1:0] ax, ay, az;
    logic signed [CW-1:0] bx, by, bz;
    logic signed [CW-1:0] cx, cy, cz;
  } query_t;

  typedef struct packed {
    logic signed [CW-1:0] wa, wb, wc;
    logic                 degen;
  } weights_t;

  logic clk;
  logic rst_n;

  tbc_in_if  #(.COORD_WIDTH(CW)) in_if ();
  tbc_out_if #(.COORD_WIDTH(CW)) out_if ();

  triangle_barycentric_coords #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  query_t   query_q[$];
  weights_t weights_q[$];
  int unsigned n_sent = 0;
  int unsigned n_total;
  int unsigned n_errors = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic big_t dot3(input big_t a[3], input big_t b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // returns 0 for a zero or negative divisor
  function automatic bit vertex_weight(input big_t u[3], input big_t w[3], input big_t x[3],
                                       output logic signed [CW-1:0] wt);
    big_t uw, ww, uu, ux, wx, d, n, num, den, q, hi, lo;
    uw = dot3(u, w);
    ww = dot3(w, w);
    uu = dot3(u, u);
    ux = dot3(u, x);
    wx = dot3(w, x);
    d = uu * ww - uw * uw;
    n = ux * ww - uw * wx;
    wt = '0;
    if (d <= 0) return 1'b0;
    // round half up == floor((2(D-N)2^F + D) / 2D)
    num = ((d - n) <<< (FB + 1)) + d;
    den = d <<< 1;
    q = num / den;
    if (num < 0 && q * den != num) q = q - 1;
    hi = (big_t'(1) <<< (CW - 1)) - 1;
    lo = -(big_t'(1) <<< (CW - 1));
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    wt = q[CW-1:0];
    return 1'b1;
  endfunction

  function automatic weights_t predict_weights(input query_t t);
    big_t p[3], a[3], b[3], c[3];
    big_t ab[3], ac[3], bc[3], cb[3], ca[3], ap[3], bp[3], cp[3];
    weights_t r;
    bit ok;
    p[0] = t.px; p[1] = t.py; p[2] = t.pz;
    a[0] = t.ax; a[1] = t.ay; a[2] = t.az;
    b[0] = t.bx; b[1] = t.by; b[2] = t.bz;
    c[0] = t.cx; c[1] = t.cy; c[2] = t.cz;
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      bc[i] = c[i] - b[i];
      cb[i] = b[i] - c[i];
      ca[i] = a[i] - c[i];
      ap[i] = p[i] - a[i];
      bp[i] = p[i] - b[i];
      cp[i] = p[i] - c[i];
    end
    ok = vertex_weight(ab, cb, ap, r.wa);
    ok = vertex_weight(bc, ac, bp, r.wb) && ok;
    ok = vertex_weight(ca, ab, cp, r.wc) && ok;
    if (!ok) begin
      r.wa = '0;
      r.wb = '0;
      r.wc = '0;
    end
    r.degen = !ok;
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_small();
    // about +-16.0 in Q16.16
    return $signed(CW'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
  endfunction

  function automatic query_t rand_query();
    query_t t;
    int unsigned kind;
    logic signed [CW-1:0] k;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      t.px = rand_small(); t.py = rand_small(); t.pz = rand_small();
      t.ax = rand_small(); t.ay = rand_small(); t.az = rand_small();
      t.bx = rand_small(); t.by = rand_small(); t.bz = rand_small();
      t.cx = rand_small(); t.cy = rand_small(); t.cz = rand_small();
      if (kind < 28) begin
        // collinear: C = A + k*(B-A), small integer k
        k = $signed(CW'($urandom_range(0, 6))) - 3;
        t.bx = t.ax + ((t.bx - t.ax) >>> 4);
        t.by = t.ay + ((t.by - t.ay) >>> 4);
        t.bz = t.az + ((t.bz - t.az) >>> 4);
        t.cx = t.ax + k * (t.bx - t.ax);
        t.cy = t.ay + k * (t.by - t.ay);
        t.cz = t.az + k * (t.bz - t.az);
      end else if (kind < 32) begin
        t.cx = t.bx; t.cy = t.by; t.cz = t.bz;
      end else if (kind < 38) begin
        // point on a vertex or an edge midpoint
        case ($urandom_range(0, 2))
          0: begin t.px = t.ax; t.py = t.ay; t.pz = t.az; end
          1: begin t.px = t.bx; t.py = t.by; t.pz = t.bz; end
          default: begin
            t.px = (t.ax >>> 1) + (t.cx >>> 1);
            t.py = (t.ay >>> 1) + (t.cy >>> 1);
            t.pz = (t.az >>> 1) + (t.cz >>> 1);
          end
        endcase
      end else if (kind < 45) begin
        // needle triangle: weights far outside range
        t.cx = t.ax + $signed(CW'($urandom_range(0, 2))) - 1;
        t.cy = t.ay + 1;
        t.cz = t.az;
        t.px = $urandom;
      end
    end
    return t;
  endfunction

  function automatic query_t make_query(input logic signed [CW-1:0] px, py, pz,
                                        ax, ay, az, bx, by, bz, cx, cy, cz);
    query_t t;
    t.px = px; t.py = py; t.pz = pz;
    t.ax = ax; t.ay = ay; t.az = az;
    t.bx = bx; t.by = by; t.bz = bz;
    t.cx = cx; t.cy = cy; t.cz = cz;
    return t;
  endfunction

  // phase 0: sender 24% idle, receiver 83%; phase 1 swapped; phase 2 no idling
  function automatic int unsigned sender_idle_pct();
    if (n_sent < n_total / 3) return 24;
    if (n_sent < 2 * n_total / 3) return 83;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (n_sent < n_total / 3) return 83;
    if (n_sent < 2 * n_total / 3) return 24;
    return 0;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid    <= 1'b0;
      in_if.point_x  <= '0; in_if.point_y  <= '0; in_if.point_z  <= '0;
      in_if.vert_a_x <= '0; in_if.vert_a_y <= '0; in_if.vert_a_z <= '0;
      in_if.vert_b_x <= '0; in_if.vert_b_y <= '0; in_if.vert_b_z <= '0;
      in_if.vert_c_x <= '0; in_if.vert_c_y <= '0; in_if.vert_c_z <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (query_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
        query_t t;
        t = query_q.pop_front();
        weights_q.push_back(predict_weights(t));
        n_sent <= n_sent + 1;
        in_if.valid    <= 1'b1;
        in_if.point_x  <= t.px; in_if.point_y  <= t.py; in_if.point_z  <= t.pz;
        in_if.vert_a_x <= t.ax; in_if.vert_a_y <= t.ay; in_if.vert_a_z <= t.az;
        in_if.vert_b_x <= t.bx; in_if.vert_b_y <= t.by; in_if.vert_b_z <= t.bz;
        in_if.vert_c_x <= t.cx; in_if.vert_c_y <= t.cy; in_if.vert_c_z <= t.cz;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= $urandom_range(0, 99) >= receiver_idle_pct();
      if (out_if.valid && out_if.ready) begin
        if (weights_q.size() == 0) begin
          $error("result transfer with nothing expected");
          n_errors <= n_errors + 1;
        end else begin
          weights_t e;
          bit bad;
          e = weights_q.pop_front();
          bad = 1'b0;
          if (out_if.weight_a !== e.wa) begin
            $error("weight_a: expected %0d, got %0d", e.wa, out_if.weight_a);
            bad = 1'b1;
          end
          if (out_if.weight_b !== e.wb) begin
            $error("weight_b: expected %0d, got %0d", e.wb, out_if.weight_b);
            bad = 1'b1;
          end
          if (out_if.weight_c !== e.wc) begin
            $error("weight_c: expected %0d, got %0d", e.wc, out_if.weight_c);
            bad = 1'b1;
          end
          if (out_if.degenerate !== e.degen) begin
            $error("degenerate: expected %0b, got %0b", e.degen, out_if.degenerate);
            bad = 1'b1;
          end
          if (bad) begin
            n_errors <= n_errors + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic signed [CW-1:0] one, mx, mn;
    one = 32'sh0001_0000;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    rst_n = 1'b0;

    // directed: unit triangle, vertices, centroid, outside points
    query_q.push_back(make_query(0, 0, 0, 0, 0, 0, one, 0, 0, 0, one, 0));
    query_q.push_back(make_query(one, 0, 0, 0, 0, 0, one, 0, 0, 0, one, 0));
    query_q.push_back(make_query(0, one, 0, 0, 0, 0, one, 0, 0, 0, one, 0));
    query_q.push_back(make_query(32'sh5555, 32'sh5555, 32'sh5555, 0, 0, 0, one, 0, 0,
                                 0, one, 0));
    query_q.push_back(make_query(-one, -one, one, 0, 0, 0, one, 0, 0, 0, 0, one));
    query_q.push_back(make_query(mx, mn, mx, 0, 0, 0, one, 0, 0, 0, one, 0));
    // extreme coordinates
    query_q.push_back(make_query(mx, mx, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn));
    query_q.push_back(make_query(mn, mn, mn, mx, mx, mx, mn, mx, mx, mx, mn, mx));
    query_q.push_back(make_query(0, 0, 0, mn, mx, 0, mx, mn, mx, 0, mn, mx));
    query_q.push_back(make_query(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    query_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // degenerate: coincident pair, collinear
    query_q.push_back(make_query(one, one, 0, 0, 0, 0, one, 0, 0, one, 0, 0));
    query_q.push_back(make_query(0, 0, one, 0, 0, 0, one, one, one, 2*one, 2*one, 2*one));
    query_q.push_back(make_query(mn, mx, 0, mn, mn, mn, 0, 0, 0, mx, mx, mx));
    // sliver triangle: huge weights, saturation
    query_q.push_back(make_query(mx, 0, 0, 0, 0, 0, one, 0, 0, 0, 1, 0));
    query_q.push_back(make_query(mn, 0, 0, 0, 0, 0, one, 0, 0, 0, 1, 0));
    query_q.push_back(make_query(0, mx, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    // small coordinates: weights of plus and minus one half
    query_q.push_back(make_query(1, 0, 0, 0, 0, 0, 2, 0, 0, 0, 2, 0));
    query_q.push_back(make_query(-1, 0, 0, 0, 0, 0, 2, 0, 0, 0, 2, 0));
    for (int i = 0; i < N_RANDOM; i++) query_q.push_back(rand_query());
    n_total = query_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (query_q.size() != 0 || weights_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && weights_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
